// File: hw/rtl/bdpc_pkg.sv
`timescale 1ns / 1ps

package bdpc_pkg;

    localparam int TIMER_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int TAP_W     = 3;
    localparam int EV_W      = 4;

    localparam logic [TAP_W-1:0] TAP_MAX = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTER_TAP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOGGLE     = 3'd5;

    // Event codes.
    localparam logic [EV_W-1:0] EV_START    = 4'd0;
    localparam logic [EV_W-1:0] EV_PROGRESS = 4'd1;
    localparam logic [EV_W-1:0] EV_SHORT    = 4'd2;
    localparam logic [EV_W-1:0] EV_LONG     = 4'd3;
    localparam logic [EV_W-1:0] EV_VLONG    = 4'd4;
    localparam logic [EV_W-1:0] EV_RELEASED = 4'd5;
    localparam logic [EV_W-1:0] EV_TAP1     = 4'd6;
    localparam logic [EV_W-1:0] EV_TLOW     = 4'd10;
    localparam logic [EV_W-1:0] EV_THIGH    = 4'd11;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] very_long_press_ms;
        logic [CFG_W-1:0] inter_tap_ms;
        logic             active_low;
        logic             toggle_mode;
    } cfg_t;

    // Events caused by one tick: count (0 to 2) and the codes in order.
    typedef struct packed {
        logic [1:0]      n;
        logic [EV_W-1:0] ev0;
        logic [EV_W-1:0] ev1;
    } ev_pair_t;

    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
        return (&t) ? t : t + TIMER_W'(1);
    endfunction

endpackage

// File: hw/rtl/bdpc_classify.sv
`timescale 1ns / 1ps

module bdpc_classify (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              raw,
    input  bdpc_pkg::cfg_t    cfg,
    output bdpc_pkg::ev_pair_t pair
);
    import bdpc_pkg::*;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_START    = 8'b0000_0010,
        PH_PROGRESS = 8'b0000_0100,
        PH_VLONG    = 8'b0000_1000,
        PH_WAITREL  = 8'b0001_0000,
        PH_RELEASED = 8'b0010_0000,
        PH_TLOW     = 8'b0100_0000,
        PH_THIGH    = 8'b1000_0000
    } phase_t;

    logic               level_reg, level_next;
    logic [TIMER_W-1:0] mis_reg, mis_next;
    phase_t             phase_reg, phase_next;
    logic [TIMER_W-1:0] hold_reg, hold_next;
    logic [TIMER_W-1:0] gap_reg, gap_next;
    logic [TAP_W-1:0]   tap_reg, tap_next;

    always_comb
    begin
        logic [TIMER_W-1:0] mis_inc;
        logic               pressed;
        logic [TAP_W-1:0]   tap_inc;
        phase_t             want;

        level_next = level_reg;
        mis_next   = '0;
        phase_next = phase_reg;
        hold_next  = hold_reg;
        gap_next   = gap_reg;
        tap_next   = tap_reg;
        pair       = '0;
        want       = PH_TLOW;
        pressed    = 1'b0;
        tap_inc    = '0;

        // Debounce: take the raw level once it has differed long enough.
        mis_inc = sat_inc(mis_reg);
        if (raw != level_reg) begin
            if (32'(mis_inc) >= 32'(cfg.debounce_ms)) begin
                level_next = raw;
            end
            else begin
                mis_next = mis_inc;
            end
        end

        if (cfg.toggle_mode) begin
            want = level_next ? PH_THIGH : PH_TLOW;
            if (phase_reg != want) begin
                pair.n     = 2'd1;
                pair.ev0   = level_next ? EV_THIGH : EV_TLOW;
                phase_next = want;
            end
        end
        else begin
            // Leaving toggle mode starts the classifier from a clean state.
            if (phase_reg == PH_TLOW || phase_reg == PH_THIGH) begin
                phase_next = PH_IDLE;
                hold_next  = '0;
                gap_next   = '0;
                tap_next   = '0;
            end
            pressed = cfg.active_low ? !level_next : level_next;
            tap_inc = (tap_next < TAP_MAX) ? tap_next + TAP_W'(1) : tap_next;

            case (phase_next)
                PH_START:
                begin
                    hold_next = sat_inc(hold_next);
                    if (cfg.long_press_ms == '0) begin
                        pair.n     = 2'd1;
                        pair.ev0   = EV_SHORT;
                        phase_next = PH_WAITREL;
                        tap_next   = tap_inc;
                    end
                    else if (32'(hold_next) >= 32'(cfg.long_press_ms)) begin
                        pair.n = 2'd1;
                        if (cfg.very_long_press_ms == '0) begin
                            pair.ev0   = EV_LONG;
                            phase_next = PH_WAITREL;
                        end
                        else begin
                            pair.ev0   = EV_PROGRESS;
                            phase_next = PH_PROGRESS;
                        end
                    end
                    else if (!pressed) begin
                        pair.n     = 2'd2;
                        pair.ev0   = EV_SHORT;
                        pair.ev1   = EV_RELEASED;
                        tap_next   = tap_inc;
                        phase_next = PH_RELEASED;
                        gap_next   = '0;
                    end
                end
                PH_PROGRESS:
                begin
                    hold_next = sat_inc(hold_next);
                    if (32'(hold_next) >= 32'(cfg.very_long_press_ms)) begin
                        pair.n     = 2'd1;
                        pair.ev0   = EV_VLONG;
                        phase_next = PH_VLONG;
                    end
                    else if (!pressed) begin
                        pair.n     = 2'd2;
                        pair.ev0   = EV_LONG;
                        pair.ev1   = EV_RELEASED;
                        phase_next = PH_RELEASED;
                        gap_next   = '0;
                    end
                end
                PH_VLONG, PH_WAITREL:
                begin
                    hold_next = sat_inc(hold_next);
                    if (!pressed) begin
                        pair.n     = 2'd1;
                        pair.ev0   = EV_RELEASED;
                        phase_next = PH_RELEASED;
                        gap_next   = '0;
                    end
                end
                PH_RELEASED:
                begin
                    gap_next = sat_inc(gap_next);
                    if (32'(gap_next) >= 32'(cfg.inter_tap_ms)) begin
                        if (tap_next != '0) begin
                            pair.n   = 2'd1;
                            pair.ev0 = EV_TAP1 + EV_W'(tap_next) - EV_W'(1);
                        end
                        phase_next = PH_IDLE;
                        gap_next   = '0;
                        tap_next   = '0;
                    end
                    // A new press inside the gap keeps counting taps.
                    if (pressed) begin
                        if (pair.n == 2'd0) begin
                            pair.ev0 = EV_START;
                        end
                        else begin
                            pair.ev1 = EV_START;
                        end
                        pair.n     = pair.n + 2'd1;
                        phase_next = PH_START;
                        hold_next  = '0;
                        gap_next   = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (pressed) begin
                        pair.n     = 2'd1;
                        pair.ev0   = EV_START;
                        phase_next = PH_START;
                        hold_next  = '0;
                        gap_next   = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            level_reg <= 1'b1;
            mis_reg   <= '0;
            phase_reg <= PH_IDLE;
            hold_reg  <= '0;
            gap_reg   <= '0;
            tap_reg   <= '0;
        end
        else if (step) begin
            level_reg <= level_next;
            mis_reg   <= mis_next;
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            gap_reg   <= gap_next;
            tap_reg   <= tap_next;
        end
    end

endmodule

// File: hw/rtl/button_debounce_press_classifier_core.sv
`timescale 1ns / 1ps
// The first event of a request is registered in the input stage and then in the event queue,
// where it can be taken; the input stage holds while the queue lacks room for two events.
// Throughput: one request per cycle while the four-entry event queue has room for two events;
// a request that causes two events drains at one event per cycle while out_ready is high, so a
// stream of those stalls the input stage. Reset sets the control registers to their defaults,
// the debounced level high, all timers and the tap count to zero, and empties the event queue.

module button_debounce_press_classifier_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bdpc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           raw_level,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bdpc_pkg::EV_W-1:0]      event_res,
    output logic                           last
);
    import bdpc_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef struct packed {
        logic [EV_W-1:0] ev;
        logic            last;
    } q_entry_t;

    cfg_t               cfg_reg;
    logic               s1_valid_reg;
    logic               s1_raw_reg;
    ev_pair_t           pair;
    logic               s1_adv;
    logic               pop;
    logic [1:0]         push_n;

    q_entry_t           q_mem [QDEPTH];
    logic [QPTR_W-1:0]  wp_reg, rp_reg;
    logic [QCNT_W-1:0]  cnt_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.debounce_ms        <= 16'd20;
            cfg_reg.long_press_ms      <= 16'd3000;
            cfg_reg.very_long_press_ms <= 16'd10000;
            cfg_reg.inter_tap_ms       <= 16'd500;
            cfg_reg.active_low         <= 1'b1;
            cfg_reg.toggle_mode        <= 1'b0;
        end
        else if (cfg_we) begin
            case (cfg_index)
                REG_DEBOUNCE:   cfg_reg.debounce_ms        <= cfg_wdata;
                REG_LONG:       cfg_reg.long_press_ms      <= cfg_wdata;
                REG_VERY_LONG:  cfg_reg.very_long_press_ms <= cfg_wdata;
                REG_INTER_TAP:  cfg_reg.inter_tap_ms       <= cfg_wdata;
                REG_ACTIVE_LOW: cfg_reg.active_low         <= cfg_wdata[0];
                REG_TOGGLE:     cfg_reg.toggle_mode        <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    // The input stage moves on only when the queue can take two events.
    assign s1_adv   = s1_valid_reg && (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            s1_raw_reg <= raw_level;
        end
    end

    bdpc_classify u_classify (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_adv),
        .raw   (s1_raw_reg),
        .cfg   (cfg_reg),
        .pair  (pair)
    );

    assign push_n    = s1_adv ? pair.n : 2'd0;
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign event_res = q_mem[rp_reg].ev;
    assign last      = q_mem[rp_reg].last;

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0) begin
            q_mem[wp_reg].ev   <= pair.ev0;
            q_mem[wp_reg].last <= (push_n == 2'd1);
        end
        if (push_n == 2'd2) begin
            q_mem[wp_reg + QPTR_W'(1)].ev   <= pair.ev1;
            q_mem[wp_reg + QPTR_W'(1)].last <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            wp_reg  <= wp_reg + QPTR_W'(push_n);
            rp_reg  <= rp_reg + QPTR_W'(pop);
            cnt_reg <= cnt_reg + QCNT_W'(push_n) - QCNT_W'(pop);
        end
    end

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("event queue count above its depth");

    a_pair_whole: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> cnt_reg >= QCNT_W'(2))
        else $error("event without last flag has no follower in the queue");

    a_pair_count: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> pair.n != 2'd3)
        else $error("classifier reports more than two events");

    a_stage_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted request lost before the classifier");
`endif

endmodule
